[src/pressure_sensor_compensation_assert.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the pressure sensor compensation block
// Shared concurrent assertion forms, clocked and reset-qualified.
// ----------------------------------------------------------------------------
`ifndef PRESSURE_SENSOR_COMPENSATION_ASSERT_SVH
`define PRESSURE_SENSOR_COMPENSATION_ASSERT_SVH

// Consequent holds in the same cycle as the antecedent.
`define PSC_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Consequent holds in the cycle after the antecedent.
`define PSC_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[src/psc_pkg.sv]
// ----------------------------------------------------------------------------
// psc_pkg
// Types, constants and helper functions of the pressure compensation block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
package psc_pkg;

  typedef struct packed {
    logic        action;
    logic [18:0] raw_sample;
  } psc_in_t;

  typedef struct packed {
    logic               kind;
    logic signed [15:0] temperature_tenths;
    logic signed [31:0] pressure_pa;
    logic               div_error;
  } psc_out_t;

  typedef enum logic [3:0] {
    S_IDLE, S_T_MUL, S_T_DIV, S_P_SQ, S_P_X1B, S_P_X2A, S_P_X1C, S_P_X2D,
    S_P_B4, S_P_B7, S_P_DIV, S_P_M8, S_P_M9, S_P_M10, S_OUT
  } psc_state_e;

  localparam logic [2:0] CFG_AC1_AC2 = 3'd0;
  localparam logic [2:0] CFG_AC3_AC4 = 3'd1;
  localparam logic [2:0] CFG_AC5_AC6 = 3'd2;
  localparam logic [2:0] CFG_B1_B2   = 3'd3;
  localparam logic [2:0] CFG_MC_MD   = 3'd4;
  localparam logic [2:0] CFG_OSS     = 3'd5;

  localparam logic [5:0]  WORD_BITS = 6'd32;
  localparam logic [31:0] B6_OFFSET = 32'd4000;
  localparam logic [31:0] P_COEF_A  = 32'd3038;
  localparam logic [31:0] P_COEF_B  = 32'hFFFF_E343;
  localparam logic [31:0] P_OFFSET  = 32'd3791;
  localparam logic [31:0] B7_SCALE  = 32'd50000;
  localparam logic [31:0] B4_BIAS   = 32'd32768;

  function automatic logic [31:0] sx16(input logic [15:0] v);
    return {{16{v[15]}}, v};
  endfunction

  function automatic logic [31:0] asr(input logic [31:0] v, input logic [4:0] s);
    return 32'($signed(v) >>> s);
  endfunction

  function automatic logic [15:0] tenths(input logic [31:0] b5);
    logic [31:0] t;
    t = asr(b5 + 32'd8, 5'd4);
    if ($signed(t) < -32'sd32768) begin
      return 16'h8000;
    end else if ($signed(t) > 32'sd32767) begin
      return 16'h7FFF;
    end
    return t[15:0];
  endfunction

endpackage
`default_nettype wire

[src/psc_mul.sv]
// ----------------------------------------------------------------------------
// psc_mul
// Bit-serial 32 by 32 multiplier giving the low 32 product bits.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module psc_mul (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [31:0] a_i,
  input  logic [31:0] b_i,
  output logic        done_o,
  output logic [31:0] prod_o
);
  import psc_pkg::*;

  logic [31:0] acc_q, acc_d, a_q, a_d, b_q, b_d;
  logic [5:0]  cnt_q, cnt_d;
  logic        done_q, done_d;

  always_comb begin
    acc_d  = acc_q;
    a_d    = a_q;
    b_d    = b_q;
    cnt_d  = cnt_q;
    done_d = 1'b0;
    if (start_i) begin
      acc_d = '0;
      a_d   = a_i;
      b_d   = b_i;
      cnt_d = WORD_BITS;
    end else if (cnt_q != 6'd0) begin
      if (b_q[0]) begin
        acc_d = acc_q + a_q;
      end
      a_d    = {a_q[30:0], 1'b0};
      b_d    = {1'b0, b_q[31:1]};
      cnt_d  = cnt_q - 6'd1;
      done_d = (cnt_q == 6'd1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
    a_q   <= a_d;
    b_q   <= b_d;
  end

  assign done_o = done_q;
  assign prod_o = acc_q;
endmodule
`default_nettype wire

[src/psc_div.sv]
// ----------------------------------------------------------------------------
// psc_div
// Restoring unsigned 32 by 32 divider producing one quotient bit per cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module psc_div (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [31:0] num_i,
  input  logic [31:0] den_i,
  output logic        done_o,
  output logic [31:0] quot_o
);
  import psc_pkg::*;

  logic [31:0] rem_q, rem_d, num_q, num_d, den_q, den_d;
  logic [32:0] trial;
  logic [5:0]  cnt_q, cnt_d;
  logic        done_q, done_d;

  always_comb begin
    rem_d  = rem_q;
    num_d  = num_q;
    den_d  = den_q;
    cnt_d  = cnt_q;
    done_d = 1'b0;
    trial  = {rem_q, num_q[31]} - {1'b0, den_q};
    if (start_i) begin
      rem_d = '0;
      num_d = num_i;
      den_d = den_i;
      cnt_d = WORD_BITS;
    end else if (cnt_q != 6'd0) begin
      if (!trial[32]) begin
        rem_d = trial[31:0];
        num_d = {num_q[30:0], 1'b1};
      end else begin
        rem_d = {rem_q[30:0], num_q[31]};
        num_d = {num_q[30:0], 1'b0};
      end
      cnt_d  = cnt_q - 6'd1;
      done_d = (cnt_q == 6'd1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    num_q <= num_d;
    den_q <= den_d;
  end

  assign done_o = done_q;
  assign quot_o = num_q;
endmodule
`default_nettype wire

[src/pressure_sensor_compensation.sv]
// ----------------------------------------------------------------------------
// pressure_sensor_compensation
// Integer barometer compensation with a serial multiplier and divider.
// ----------------------------------------------------------------------------
// Items enter on the in channel (valid/ready) and each gives one result on
// the out channel (valid/ready). Calibration words are written through a
// plain write port; the user must do so only while the block is idle, which
// the block itself does not enforce. One item is worked on at a time: a
// temperature item needs one product and a divide, and a pressure item needs
// ten products and a divide. Each product is formed in the bit-serial
// multiplier and each quotient in the bit-serial divider.
// An item whose divisor is zero finishes early with the error flag set.
// The result sits in an output register; the next item is accepted while it
// waits, and the block stalls before loading a new result until the
// receiver takes the old one.
// Reset clears the calibration words, sets oversampling to three and clears
// the stored intermediate temperature value.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module pressure_sensor_compensation (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  psc_pkg::psc_in_t   in_data_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output psc_pkg::psc_out_t  out_data_o,
  input  logic               cfg_we_i,
  input  logic [2:0]         cfg_idx_i,
  input  logic [31:0]        cfg_data_i
);
  import psc_pkg::*;

  psc_state_e  state_q, state_d;
  logic        launched_q, launched_d;
  logic [31:0] ac1_ac2_q, ac3_ac4_q, ac5_ac6_q, b1_b2_q, mc_md_q;
  logic [1:0]  oss_q;
  logic [31:0] b5_q, b5_d;
  logic        act_q, act_d;
  logic [18:0] raw_q, raw_d;
  logic [31:0] x1_q, x1_d, sq_q, sq_d, b3_q, b3_d, b4_q, b4_d, b7_q, b7_d;
  logic [31:0] den_q, den_d, pr_q, pr_d;
  logic [15:0] temp_q, temp_d;
  logic        err_q, err_d;
  logic        out_valid_q, out_valid_d;
  psc_out_t    out_q, out_d;
  logic        load_out;

  logic        mul_start, mul_done, div_start, div_done;
  logic [31:0] mul_a, mul_b, mul_p, div_n, div_d, div_q;
  logic [31:0] b6, mc_num, t_x1, t_den, t_q, x3;

  psc_mul u_mul (
    .clk_i, .rst_ni, .start_i(mul_start), .a_i(mul_a), .b_i(mul_b),
    .done_o(mul_done), .prod_o(mul_p)
  );

  psc_div u_div (
    .clk_i, .rst_ni, .start_i(div_start), .num_i(div_n), .den_i(div_d),
    .done_o(div_done), .quot_o(div_q)
  );

  assign b6     = b5_q - B6_OFFSET;
  assign mc_num = {{5{mc_md_q[31]}}, mc_md_q[31:16], 11'b0};

  always_comb begin
    state_d    = state_q;
    launched_d = launched_q;
    b5_d = b5_q; act_d = act_q; raw_d = raw_q; x1_d = x1_q; sq_d = sq_q;
    b3_d = b3_q; b4_d = b4_q; b7_d = b7_q; den_d = den_q; pr_d = pr_q;
    temp_d = temp_q; err_d = err_q;
    in_ready_o = 1'b0;
    load_out   = 1'b0;
    mul_start  = 1'b0; mul_a = '0; mul_b = '0;
    div_start  = 1'b0; div_n = '0; div_d = '0;
    t_x1  = asr(mul_p, 5'd15);
    t_den = t_x1 + sx16(mc_md_q[15:0]);
    t_q   = (mc_num[31] ^ den_q[31]) ? 32'd0 - div_q : div_q;
    x3    = '0;
    case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          act_d   = in_data_i.action;
          raw_d   = in_data_i.raw_sample;
          temp_d  = '0;
          pr_d    = '0;
          err_d   = 1'b0;
          state_d = in_data_i.action ? S_P_SQ : S_T_MUL;
        end
      end
      S_OUT: begin
        if (!out_valid_q || out_ready_i) begin
          load_out = 1'b1;
          state_d  = S_IDLE;
        end
      end
      S_T_DIV, S_P_DIV: begin
        if (state_q == S_T_DIV) begin
          div_n = mc_num[31] ? 32'd0 - mc_num : mc_num;
          div_d = den_q[31] ? 32'd0 - den_q : den_q;
        end else begin
          div_n = b7_q[31] ? b7_q : {b7_q[30:0], 1'b0};
          div_d = b4_q;
        end
        if (!launched_q) begin
          div_start  = 1'b1;
          launched_d = 1'b1;
        end else if (div_done) begin
          launched_d = 1'b0;
          if (state_q == S_T_DIV) begin
            b5_d    = x1_q + t_q;
            temp_d  = tenths(x1_q + t_q);
            state_d = S_OUT;
          end else begin
            pr_d    = b7_q[31] ? {div_q[30:0], 1'b0} : div_q;
            state_d = S_P_M8;
          end
        end
      end
      default: begin
        case (state_q)
          S_T_MUL: begin
            mul_a = {16'b0, raw_q[15:0]} - {16'b0, ac5_ac6_q[15:0]};
            mul_b = {16'b0, ac5_ac6_q[31:16]};
          end
          S_P_SQ:  begin mul_a = b6; mul_b = b6; end
          S_P_X1B: begin mul_a = sx16(b1_b2_q[15:0]); mul_b = sq_q; end
          S_P_X2A: begin mul_a = sx16(ac1_ac2_q[15:0]); mul_b = b6; end
          S_P_X1C: begin mul_a = sx16(ac3_ac4_q[31:16]); mul_b = b6; end
          S_P_X2D: begin mul_a = sx16(b1_b2_q[31:16]); mul_b = sq_q; end
          S_P_B4:  begin mul_a = {16'b0, ac3_ac4_q[15:0]}; mul_b = x1_q + B4_BIAS; end
          S_P_B7: begin
            mul_a = {13'b0, raw_q} - b3_q;
            mul_b = B7_SCALE >> oss_q;
          end
          S_P_M8:  begin mul_a = asr(pr_q, 5'd8); mul_b = asr(pr_q, 5'd8); end
          S_P_M9:  begin mul_a = x1_q; mul_b = P_COEF_A; end
          default: begin mul_a = P_COEF_B; mul_b = pr_q; end
        endcase
        if (!launched_q) begin
          mul_start  = 1'b1;
          launched_d = 1'b1;
        end else if (mul_done) begin
          launched_d = 1'b0;
          case (state_q)
            S_T_MUL: begin
              x1_d  = t_x1;
              den_d = t_den;
              if (t_den == 32'd0) begin
                err_d   = 1'b1;
                state_d = S_OUT;
              end else begin
                state_d = S_T_DIV;
              end
            end
            S_P_SQ:  begin sq_d = asr(mul_p, 5'd12); state_d = S_P_X1B; end
            S_P_X1B: begin x1_d = asr(mul_p, 5'd11); state_d = S_P_X2A; end
            S_P_X2A: begin
              x3      = x1_q + asr(mul_p, 5'd11);
              b3_d    = asr(((sx16(ac1_ac2_q[31:16]) << 2) + x3 << oss_q) + 32'd2, 5'd2);
              state_d = S_P_X1C;
            end
            S_P_X1C: begin x1_d = asr(mul_p, 5'd13); state_d = S_P_X2D; end
            S_P_X2D: begin
              x1_d    = asr(x1_q + asr(mul_p, 5'd16) + 32'd2, 5'd2);
              state_d = S_P_B4;
            end
            S_P_B4:  begin b4_d = mul_p >> 15; state_d = S_P_B7; end
            S_P_B7: begin
              b7_d = mul_p;
              if (b4_q == 32'd0) begin
                err_d   = 1'b1;
                state_d = S_OUT;
              end else begin
                state_d = S_P_DIV;
              end
            end
            S_P_M8:  begin x1_d = mul_p; state_d = S_P_M9; end
            S_P_M9:  begin x1_d = asr(mul_p, 5'd16); state_d = S_P_M10; end
            default: begin
              pr_d    = pr_q + asr(x1_q + asr(mul_p, 5'd16) + P_OFFSET, 5'd4);
              temp_d  = tenths(b5_q);
              state_d = S_OUT;
            end
          endcase
        end
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q && !out_ready_i;
    out_d       = out_q;
    if (load_out) begin
      out_valid_d = 1'b1;
      out_d       = {act_q, temp_q, pr_q, err_q};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      launched_q  <= 1'b0;
      out_valid_q <= 1'b0;
      b5_q        <= '0;
      ac1_ac2_q   <= '0;
      ac3_ac4_q   <= '0;
      ac5_ac6_q   <= '0;
      b1_b2_q     <= '0;
      mc_md_q     <= '0;
      oss_q       <= 2'd3;
    end else begin
      state_q     <= state_d;
      launched_q  <= launched_d;
      out_valid_q <= out_valid_d;
      b5_q        <= b5_d;
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_AC1_AC2: ac1_ac2_q <= cfg_data_i;
          CFG_AC3_AC4: ac3_ac4_q <= cfg_data_i;
          CFG_AC5_AC6: ac5_ac6_q <= cfg_data_i;
          CFG_B1_B2:   b1_b2_q   <= cfg_data_i;
          CFG_MC_MD:   mc_md_q   <= cfg_data_i;
          CFG_OSS:     oss_q     <= cfg_data_i[1:0];
          default:     ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    act_q  <= act_d;
    raw_q  <= raw_d;
    x1_q   <= x1_d;
    sq_q   <= sq_d;
    b3_q   <= b3_d;
    b4_q   <= b4_d;
    b7_q   <= b7_d;
    den_q  <= den_d;
    pr_q   <= pr_d;
    temp_q <= temp_d;
    err_q  <= err_d;
    out_q  <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;
endmodule
`default_nettype wire

[src/psc_checker.sv]
// ----------------------------------------------------------------------------
// psc_checker
// Port-level assertions for the pressure compensation block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module psc_checker (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  logic               in_ready_o,
  input  psc_pkg::psc_in_t   in_data_i,
  input  logic               out_valid_o,
  input  logic               out_ready_i,
  input  psc_pkg::psc_out_t  out_data_o
);
  import psc_pkg::*;
`include "pressure_sensor_compensation_assert.svh"

  `PSC_ASSERT_NXT(a_in_hold, clk_i, rst_ni, in_valid_i && !in_ready_o,
    in_valid_i && $stable(in_data_i), "Item changed while waiting.")
  `PSC_ASSERT_NXT(a_out_hold, clk_i, rst_ni, out_valid_o && !out_ready_i,
    out_valid_o && $stable(out_data_o), "Result changed while stalled.")
  `PSC_ASSERT_NXT(a_one_item, clk_i, rst_ni, in_valid_i && in_ready_o,
    !in_ready_o, "Item accepted while another is in progress.")
  `PSC_ASSERT_IMP(a_temp_no_pres, clk_i, rst_ni, out_valid_o && !out_data_o.kind,
    out_data_o.pressure_pa == 32'sd0, "Temperature result carries a pressure.")
  `PSC_ASSERT_IMP(a_err_zero, clk_i, rst_ni, out_valid_o && out_data_o.div_error,
    out_data_o.temperature_tenths == 16'sd0 && out_data_o.pressure_pa == 32'sd0,
    "Error result is not zero.")
endmodule

bind pressure_sensor_compensation psc_checker u_psc_checker (
  .clk_i(clk_i), .rst_ni(rst_ni), .in_valid_i(in_valid_i), .in_ready_o(in_ready_o),
  .in_data_i(in_data_i), .out_valid_o(out_valid_o), .out_ready_i(out_ready_i),
  .out_data_o(out_data_o)
);
`default_nettype wire

[tb/testbench.sv]
// ----------------------------------------------------------------------------
// Pressure compensation testbench
// Drives temperature and pressure items under several calibration settings,
// predicts each result with an independent integer model and compares every
// field of every result in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module testbench;
  import psc_pkg::*;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  psc_in_t in_data_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  psc_out_t out_data_o;
  logic cfg_we_i = 1'b0;
  logic [2:0] cfg_idx_i = '0;
  logic [31:0] cfg_data_i = '0;

  pressure_sensor_compensation i_dut (.*);

  always #5 clk_i = ~clk_i;

  psc_in_t pending_items[$];
  psc_out_t expected_results[$];
  int errors = 0;
  int cycles = 0;
  bit calm = 1'b0;
  bit hold_sender = 1'b0;
  int send_gap = 0;
  int recv_gap = 0;

  logic [31:0] cal_words[5];
  logic [1:0] cal_oss;
  logic [31:0] stored_b5;

  task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
    $display("error: %s got %0h expected %0h", what, got, want);
    errors++;
  endtask

  function automatic logic [31:0] sra(input logic [31:0] v, input int s);
    return $signed(v) >>> s;
  endfunction

  function automatic logic [31:0] signed_quotient(input logic [31:0] a, input logic [31:0] b);
    logic [31:0] ua;
    logic [31:0] ub;
    logic [31:0] q;
    ua = a[31] ? -a : a;
    ub = b[31] ? -b : b;
    q = ua / ub;
    return (a[31] != b[31]) ? -q : q;
  endfunction

  function automatic logic [15:0] to_tenths(input logic [31:0] b5);
    logic signed [31:0] t;
    t = $signed(b5 + 32'd8) >>> 4;
    if (t < -32768) return 16'h8000;
    if (t > 32767) return 16'h7FFF;
    return t[15:0];
  endfunction

  function automatic logic [31:0] s16(input logic [15:0] v);
    return {{16{v[15]}}, v};
  endfunction

  function automatic psc_out_t compensate(input psc_in_t it);
    psc_out_t r;
    logic [31:0] x1, x2, x3, den, b6, sq, b3, b4, b7, p, raw;
    int oss;
    r = '0;
    r.kind = it.action;
    raw = {13'd0, it.raw_sample};
    if (!it.action) begin
      x1 = sra(({16'd0, raw[15:0]} - {16'd0, cal_words[CFG_AC5_AC6][15:0]})
               * {16'd0, cal_words[CFG_AC5_AC6][31:16]}, 15);
      den = x1 + s16(cal_words[CFG_MC_MD][15:0]);
      if (den == 0) begin
        r.div_error = 1'b1;
      end else begin
        x2 = signed_quotient(s16(cal_words[CFG_MC_MD][31:16]) << 11, den);
        stored_b5 = x1 + x2;
        r.temperature_tenths = to_tenths(stored_b5);
      end
    end else begin
      oss = int'(cal_oss);
      b6 = stored_b5 - 32'd4000;
      sq = sra(b6 * b6, 12);
      x1 = sra(s16(cal_words[CFG_B1_B2][15:0]) * sq, 11);
      x2 = sra(s16(cal_words[CFG_AC1_AC2][15:0]) * b6, 11);
      x3 = x1 + x2;
      b3 = sra(((s16(cal_words[CFG_AC1_AC2][31:16]) * 4 + x3) << oss) + 2, 2);
      x1 = sra(s16(cal_words[CFG_AC3_AC4][31:16]) * b6, 13);
      x2 = sra(s16(cal_words[CFG_B1_B2][31:16]) * sq, 16);
      x3 = sra(x1 + x2 + 2, 2);
      b4 = ({16'd0, cal_words[CFG_AC3_AC4][15:0]} * (x3 + 32'd32768)) >> 15;
      b7 = (raw - b3) * (32'd50000 >> oss);
      if (b4 == 0) begin
        r.div_error = 1'b1;
      end else begin
        p = b7[31] ? ((b7 / b4) << 1) : ((b7 << 1) / b4);
        x1 = sra(p, 8) * sra(p, 8);
        x1 = sra(x1 * 32'd3038, 16);
        x2 = sra(32'hFFFF_E343 * p, 16);
        p = p + sra(x1 + x2 + 32'd3791, 4);
        r.pressure_pa = p;
        r.temperature_tenths = to_tenths(stored_b5);
      end
    end
    return r;
  endfunction

  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) begin
      end
    end
  end

  bit sent_last = 1'b0;
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    sent_last <= in_valid_i && in_ready_o;
  end

  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (!in_valid_i || sent_last) begin
        if (send_gap > 0) begin
          send_gap <= send_gap - 1;
          in_valid_i <= 1'b0;
        end else if (pending_items.size() > 0 && !hold_sender) begin
          in_data_i <= pending_items.pop_front();
          in_valid_i <= 1'b1;
          if (!calm && $urandom_range(0, 5) == 0) send_gap <= $urandom_range(1, 12);
        end else begin
          in_valid_i <= 1'b0;
        end
      end
      if (recv_gap > 0) begin
        recv_gap <= recv_gap - 1;
        out_ready_i <= 1'b0;
      end else if (!calm && $urandom_range(0, 7) == 0) begin
        recv_gap <= $urandom_range(0, 11);
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) expected_results.push_back(compensate(in_data_i));
    if (out_valid_o && out_ready_i) begin
      if (expected_results.size() == 0) begin
        report("unexpected result", out_data_o, 0);
      end else begin
        psc_out_t want;
        want = expected_results.pop_front();
        if (out_data_o.kind !== want.kind) report("kind", out_data_o.kind, want.kind);
        if (out_data_o.temperature_tenths !== want.temperature_tenths)
          report("temperature_tenths", out_data_o.temperature_tenths, want.temperature_tenths);
        if (out_data_o.pressure_pa !== want.pressure_pa)
          report("pressure_pa", out_data_o.pressure_pa, want.pressure_pa);
        if (out_data_o.div_error !== want.div_error)
          report("div_error", out_data_o.div_error, want.div_error);
      end
    end
    if (cycles > 3000000) begin
      $display("pressure_sensor_compensation: mismatch");
      $finish;
    end
  end

  task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= val;
    if (idx == CFG_OSS) cal_oss = val[1:0];
    else cal_words[idx] = val;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic drain();
    wait (pending_items.size() == 0);
    @(posedge clk_i);
    while (in_valid_i || expected_results.size() > 0) @(posedge clk_i);
    repeat (400) @(posedge clk_i);
  endtask

  task automatic add_item(input logic act, input logic [18:0] raw);
    psc_in_t it;
    it.action = act;
    it.raw_sample = raw;
    pending_items.push_back(it);
  endtask

  task automatic typical_calibration();
    write_reg(CFG_AC1_AC2, {16'd408, 16'hFFC8});
    write_reg(CFG_AC3_AC4, {16'hC6A7, 16'd32741});
    write_reg(CFG_AC5_AC6, {16'd32757, 16'd23153});
    write_reg(CFG_B1_B2, {16'd6190, 16'd4});
    write_reg(CFG_MC_MD, {16'hD4BD, 16'd2868});
  endtask

  task automatic random_calibration();
    for (int i = 0; i < 5; i++) write_reg(i[2:0], $urandom);
    write_reg(CFG_OSS, $urandom_range(0, 3));
  endtask

  task automatic random_batch(input int n, input bit typical);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 2) == 0) add_item(1'b0, typical ? 19'($urandom_range(20000, 35000))
                                                     : 19'($urandom));
      else add_item(1'b1, typical ? 19'($urandom_range(20000, 65000) << cal_oss)
                                  : 19'($urandom));
    end
  endtask

  initial begin
    for (int i = 0; i < 5; i++) cal_words[i] = '0;
    cal_oss = 2'd3;
    stored_b5 = '0;
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    add_item(1'b1, 19'd1000);
    add_item(1'b0, 19'd27898);
    add_item(1'b1, 19'h7FFFF);
    drain();
    typical_calibration();
    write_reg(CFG_OSS, 32'd0);
    add_item(1'b1, 19'd23843);
    add_item(1'b0, 19'd27898);
    add_item(1'b1, 19'd23843);
    add_item(1'b0, 19'h7FFFF);
    add_item(1'b0, 19'd0);
    add_item(1'b1, 19'd0);
    add_item(1'b1, 19'h7FFFF);
    add_item(1'b0, 19'h70000);
    drain();
    write_reg(CFG_MC_MD, {16'd100, 16'd0});
    write_reg(CFG_AC5_AC6, {16'd0, 16'd0});
    add_item(1'b0, 19'd500);
    drain();
    write_reg(CFG_AC3_AC4, {16'd0, 16'd0});
    add_item(1'b1, 19'd12345);
    add_item(1'b0, 19'hFFFF);
    drain();
    write_reg(CFG_AC1_AC2, 32'hFFFF_FFFF);
    write_reg(CFG_AC3_AC4, 32'h7FFF_FFFF);
    write_reg(CFG_AC5_AC6, 32'hFFFF_FFFF);
    write_reg(CFG_B1_B2, 32'h8000_7FFF);
    write_reg(CFG_MC_MD, 32'h7FFF_8000);
    write_reg(CFG_OSS, 32'd3);
    add_item(1'b0, 19'h0);
    add_item(1'b1, 19'h7FFFF);
    add_item(1'b0, 19'hFFFF);
    add_item(1'b1, 19'h0);
    drain();
    for (int phase = 0; phase < 4; phase++) begin
      typical_calibration();
      write_reg(CFG_OSS, {30'd0, phase[1:0]});
      random_batch(200, 1'b1);
      if (phase == 1) begin
        wait (pending_items.size() <= 100);
        hold_sender = 1'b1;
        repeat (20) @(posedge clk_i);
        while (expected_results.size() > 0 || in_valid_i) @(posedge clk_i);
        hold_sender = 1'b0;
      end
      drain();
    end
    for (int phase = 0; phase < 3; phase++) begin
      random_calibration();
      random_batch(100, 1'b0);
      drain();
    end
    calm = 1'b1;
    typical_calibration();
    random_batch(150, 1'b1);
    drain();
    if (errors == 0) begin
      $display("pressure_sensor_compensation: match");
    end else begin
      $display("pressure_sensor_compensation: mismatch");
    end
    $finish;
  end
endmodule
`default_nettype wire

[sim.f]
+incdir+src
src/psc_pkg.sv
src/psc_mul.sv
src/psc_div.sv
src/pressure_sensor_compensation.sv
src/psc_checker.sv
tb/testbench.sv
